/* rtl/adsr_pkg.sv */
// adsr_pkg: shared widths, register indexes, phase codes, controller states
// and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package adsr_pkg;

  localparam int SAMPLE_W = 16;
  localparam int PHASE_W  = 3;
  localparam int POS_W    = 23;
  localparam int LEN_W    = 20;
  localparam int LEVEL_W  = 16;
  localparam int CFG_W    = 20;
  localparam int IDX_W    = 3;
  localparam int END_W    = 22;
  localparam int NUM_W    = LEN_W + LEVEL_W;
  localparam int GAIN_W   = LEVEL_W + 1;
  localparam int PROD_W   = SAMPLE_W + GAIN_W + 1;
  localparam int DIV_STEPS = LEVEL_W;
  localparam int DCNT_W   = 4;

  localparam logic [IDX_W-1:0] REG_ATTACK_LEN    = 3'd0;
  localparam logic [IDX_W-1:0] REG_DECAY_LEN     = 3'd1;
  localparam logic [IDX_W-1:0] REG_SUSTAIN_LEN   = 3'd2;
  localparam logic [IDX_W-1:0] REG_RELEASE_LEN   = 3'd3;
  localparam logic [IDX_W-1:0] REG_ATTACK_LEVEL  = 3'd4;
  localparam logic [IDX_W-1:0] REG_DECAY_LEVEL   = 3'd5;
  localparam logic [IDX_W-1:0] REG_SUSTAIN_LEVEL = 3'd6;
  localparam logic [IDX_W-1:0] REG_START_LEVEL   = 3'd7;

  localparam logic [PHASE_W-1:0] PH_ATTACK  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_DECAY   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_SUSTAIN = 3'd2;
  localparam logic [PHASE_W-1:0] PH_RELEASE = 3'd3;
  localparam logic [PHASE_W-1:0] PH_DONE    = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ENDS,
    ST_SEG,
    ST_MUL,
    ST_DIVI,
    ST_DIV,
    ST_GAIN,
    ST_PROD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic ends_load;
    logic seg_load;
    logic mul_load;
    logic div_init;
    logic div_step;
    logic gain_load;
    logic prod_load;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } status_t;

endpackage

`default_nettype wire

/* rtl/adsr_if.sv */
// Request channels of the envelope gain block: input samples and results.
// Depends on adsr_pkg for field widths.
`default_nettype none

interface adsr_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [adsr_pkg::SAMPLE_W-1:0] sample;
  logic                                restart;

  modport source (output valid, output sample, output restart, input ready);
  modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface adsr_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [adsr_pkg::SAMPLE_W-1:0] scaled;
  logic        [adsr_pkg::PHASE_W-1:0]  phase;
  logic        [adsr_pkg::POS_W-1:0]    position;

  modport source (output valid, output scaled, output phase, output position, input ready);
  modport sink   (input valid, input scaled, input phase, input position, output ready);
endinterface

`default_nettype wire

/* rtl/adsr_ctrl.sv */
// adsr_ctrl: sequencer for one request at a time through the datapath,
// plus the result valid flag. Depends on adsr_pkg.
`default_nettype none

module adsr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output adsr_pkg::cmd_t         cmd,
  input  wire adsr_pkg::status_t status
);

  adsr_pkg::state_t state, state_next;
  logic             out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= adsr_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      adsr_pkg::ST_IDLE: begin
        if (in_valid) state_next = adsr_pkg::ST_ENDS;
      end
      adsr_pkg::ST_ENDS: state_next = adsr_pkg::ST_SEG;
      adsr_pkg::ST_SEG:  state_next = adsr_pkg::ST_MUL;
      adsr_pkg::ST_MUL:  state_next = adsr_pkg::ST_DIVI;
      adsr_pkg::ST_DIVI: state_next = adsr_pkg::ST_DIV;
      adsr_pkg::ST_DIV: begin
        if (status.div_done) state_next = adsr_pkg::ST_GAIN;
      end
      adsr_pkg::ST_GAIN: state_next = adsr_pkg::ST_PROD;
      adsr_pkg::ST_PROD: state_next = adsr_pkg::ST_OUT;
      adsr_pkg::ST_OUT: begin
        if (!out_valid || out_ready) state_next = adsr_pkg::ST_IDLE;
      end
      default: state_next = adsr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      adsr_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      adsr_pkg::ST_ENDS: cmd.ends_load = 1'b1;
      adsr_pkg::ST_SEG:  cmd.seg_load  = 1'b1;
      adsr_pkg::ST_MUL:  cmd.mul_load  = 1'b1;
      adsr_pkg::ST_DIVI: cmd.div_init  = 1'b1;
      adsr_pkg::ST_DIV:  cmd.div_step  = 1'b1;
      adsr_pkg::ST_GAIN: cmd.gain_load = 1'b1;
      adsr_pkg::ST_PROD: cmd.prod_load = 1'b1;
      adsr_pkg::ST_OUT:  cmd.out_load  = !out_valid || out_ready;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> state == adsr_pkg::ST_ENDS)
    else $error("accepted request did not start processing");

  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    state == adsr_pkg::ST_DIV && status.div_done |=> state == adsr_pkg::ST_GAIN)
    else $error("divider finish not followed by gain stage");

  a_load_room: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result overwritten before it was taken");

  a_single_item: assert property (@(posedge clk) disable iff (rst)
    state != adsr_pkg::ST_IDLE |-> !in_ready)
    else $error("input ready while a request is in flight");

endmodule

`default_nettype wire

/* rtl/adsr_dp.sv */
// adsr_dp: configuration registers, position counter, segment select,
// magnitude multiply, 16-step restoring divider, gain multiply, saturation.
// Depends on adsr_pkg; driven by adsr_ctrl commands.
`default_nettype none

module adsr_dp #(
  parameter int MAX_SEGMENT_SAMPLES = 1048575
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire adsr_pkg::cmd_t                      cmd,
  output adsr_pkg::status_t                        status,
  input  wire logic                                cfg_we,
  input  wire logic        [adsr_pkg::IDX_W-1:0]    cfg_index,
  input  wire logic        [adsr_pkg::CFG_W-1:0]    cfg_data,
  input  wire logic signed [adsr_pkg::SAMPLE_W-1:0] in_sample,
  input  wire logic                                in_restart,
  output logic signed      [adsr_pkg::SAMPLE_W-1:0] out_scaled,
  output logic             [adsr_pkg::PHASE_W-1:0]  out_phase,
  output logic             [adsr_pkg::POS_W-1:0]    out_position
);

  localparam logic [adsr_pkg::END_W-1:0] MaxLen = adsr_pkg::END_W'(MAX_SEGMENT_SAMPLES);
  localparam logic [adsr_pkg::POS_W-1:0] PosMax = '1;

  function automatic logic [adsr_pkg::LEN_W-1:0] clamp_len(
    input logic [adsr_pkg::LEN_W-1:0] v
  );
    logic [adsr_pkg::END_W-1:0] wide;
    wide = {2'b00, v};
    return (wide > MaxLen) ? MaxLen[adsr_pkg::LEN_W-1:0] : v;
  endfunction

  // configuration
  logic [adsr_pkg::LEN_W-1:0]   attack_len, decay_len, sustain_len, release_len;
  logic [adsr_pkg::LEVEL_W-1:0] attack_level, decay_level, sustain_level, start_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_len    <= '0;
      decay_len     <= '0;
      sustain_len   <= '0;
      release_len   <= '0;
      attack_level  <= '0;
      decay_level   <= '0;
      sustain_level <= '0;
      start_level   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        adsr_pkg::REG_ATTACK_LEN:    attack_len    <= cfg_data[adsr_pkg::LEN_W-1:0];
        adsr_pkg::REG_DECAY_LEN:     decay_len     <= cfg_data[adsr_pkg::LEN_W-1:0];
        adsr_pkg::REG_SUSTAIN_LEN:   sustain_len   <= cfg_data[adsr_pkg::LEN_W-1:0];
        adsr_pkg::REG_RELEASE_LEN:   release_len   <= cfg_data[adsr_pkg::LEN_W-1:0];
        adsr_pkg::REG_ATTACK_LEVEL:  attack_level  <= cfg_data[adsr_pkg::LEVEL_W-1:0];
        adsr_pkg::REG_DECAY_LEVEL:   decay_level   <= cfg_data[adsr_pkg::LEVEL_W-1:0];
        adsr_pkg::REG_SUSTAIN_LEVEL: sustain_level <= cfg_data[adsr_pkg::LEVEL_W-1:0];
        adsr_pkg::REG_START_LEVEL:   start_level   <= cfg_data[adsr_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // position counter, saturating
  logic [adsr_pkg::POS_W-1:0] pos_cnt;
  logic [adsr_pkg::POS_W-1:0] pos_cur;
  logic signed [adsr_pkg::SAMPLE_W-1:0] sample_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_cnt <= '0;
    end else if (cmd.accept) begin
      if (in_restart) begin
        pos_cnt <= adsr_pkg::POS_W'(1);
      end else if (pos_cnt != PosMax) begin
        pos_cnt <= pos_cnt + adsr_pkg::POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_r <= in_sample;
      pos_cur  <= in_restart ? '0 : pos_cnt;
    end
  end

  // segment ends
  logic [adsr_pkg::LEN_W-1:0] la, ld, ls, lr;
  logic [adsr_pkg::END_W-1:0] e0, e1, e2, e3;

  always_ff @(posedge clk) begin
    if (cmd.ends_load) begin
      la <= clamp_len(attack_len);
      ld <= clamp_len(decay_len);
      ls <= clamp_len(sustain_len);
      lr <= clamp_len(release_len);
      e0 <= {2'b00, clamp_len(attack_len)};
      e1 <= {2'b00, clamp_len(attack_len)} + {2'b00, clamp_len(decay_len)};
      e2 <= {2'b00, clamp_len(attack_len)} + {2'b00, clamp_len(decay_len)}
          + {2'b00, clamp_len(sustain_len)};
      e3 <= {2'b00, clamp_len(attack_len)} + {2'b00, clamp_len(decay_len)}
          + {2'b00, clamp_len(sustain_len)} + {2'b00, clamp_len(release_len)};
    end
  end

  // segment select
  logic [adsr_pkg::PHASE_W-1:0] phase_c, phase_r;
  logic [adsr_pkg::LEVEL_W-1:0] from_c, from_r, mag_c, mag_r;
  logic                         neg_c, neg_r;
  logic [adsr_pkg::LEN_W-1:0]   k_c, k_r, len_c, len_r;
  logic [adsr_pkg::POS_W-1:0]   off0, off1, off2;

  always_comb begin
    off0 = pos_cur - {1'b0, e0};
    off1 = pos_cur - {1'b0, e1};
    off2 = pos_cur - {1'b0, e2};
    if (pos_cur < {1'b0, e0}) begin
      phase_c = adsr_pkg::PH_ATTACK;
      from_c  = start_level;
      mag_c   = attack_level;
      neg_c   = 1'b0;
      k_c     = pos_cur[adsr_pkg::LEN_W-1:0];
      len_c   = la;
    end else if (pos_cur < {1'b0, e1}) begin
      phase_c = adsr_pkg::PH_DECAY;
      from_c  = attack_level;
      neg_c   = decay_level < attack_level;
      mag_c   = neg_c ? attack_level - decay_level : decay_level - attack_level;
      k_c     = off0[adsr_pkg::LEN_W-1:0];
      len_c   = ld;
    end else if (pos_cur < {1'b0, e2}) begin
      phase_c = adsr_pkg::PH_SUSTAIN;
      from_c  = decay_level;
      neg_c   = sustain_level < decay_level;
      mag_c   = neg_c ? decay_level - sustain_level : sustain_level - decay_level;
      k_c     = off1[adsr_pkg::LEN_W-1:0];
      len_c   = ls;
    end else if (pos_cur < {1'b0, e3}) begin
      phase_c = adsr_pkg::PH_RELEASE;
      from_c  = sustain_level;
      mag_c   = sustain_level;
      neg_c   = 1'b1;
      k_c     = off2[adsr_pkg::LEN_W-1:0];
      len_c   = lr;
    end else begin
      phase_c = adsr_pkg::PH_DONE;
      from_c  = '0;
      mag_c   = '0;
      neg_c   = 1'b0;
      k_c     = '0;
      len_c   = adsr_pkg::LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.seg_load) begin
      phase_r <= phase_c;
      from_r  <= from_c;
      mag_r   <= mag_c;
      neg_r   <= neg_c;
      k_r     <= k_c;
      len_r   <= len_c;
    end
  end

  // |delta| * k, then |delta| * k / len with quotient below 2^16
  logic [adsr_pkg::NUM_W-1:0]   num_mag;
  logic [adsr_pkg::LEN_W-1:0]   rem;
  logic [adsr_pkg::LEVEL_W-1:0] quot;
  logic [adsr_pkg::DCNT_W-1:0]  div_cnt;
  logic [adsr_pkg::LEN_W:0]     trial, trial_sub;
  logic                         trial_ge;

  always_comb begin
    trial     = {rem, quot[adsr_pkg::LEVEL_W-1]};
    trial_ge  = trial >= {1'b0, len_r};
    trial_sub = trial - {1'b0, len_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      num_mag <= {{adsr_pkg::LEN_W{1'b0}}, mag_r} * {{adsr_pkg::LEVEL_W{1'b0}}, k_r};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_init) begin
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + adsr_pkg::DCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem  <= num_mag[adsr_pkg::NUM_W-1:adsr_pkg::LEVEL_W];
      quot <= num_mag[adsr_pkg::LEVEL_W-1:0];
    end else if (cmd.div_step) begin
      rem  <= trial_ge ? trial_sub[adsr_pkg::LEN_W-1:0] : trial[adsr_pkg::LEN_W-1:0];
      quot <= {quot[adsr_pkg::LEVEL_W-2:0], trial_ge};
    end
  end

  assign status.div_done = div_cnt == adsr_pkg::DCNT_W'(adsr_pkg::DIV_STEPS - 1);

  // gain and product
  logic [adsr_pkg::GAIN_W-1:0]        gain;
  logic signed [adsr_pkg::PROD_W-1:0] prod;
  logic signed [adsr_pkg::PROD_W-1:0] shifted;
  logic signed [adsr_pkg::SAMPLE_W-1:0] sat_c;

  always_ff @(posedge clk) begin
    if (cmd.gain_load) begin
      gain <= neg_r ? {1'b0, from_r} - {1'b0, quot} : {1'b0, from_r} + {1'b0, quot};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prod_load) begin
      prod <= sample_r * $signed({1'b0, gain});
    end
  end

  always_comb begin
    shifted = prod >>> 15;
    if (shifted > $signed(adsr_pkg::PROD_W'(32767))) begin
      sat_c = 16'sh7FFF;
    end else if (shifted < -$signed(adsr_pkg::PROD_W'(32768))) begin
      sat_c = -16'sh8000;
    end else begin
      sat_c = shifted[adsr_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_scaled   <= sat_c;
      out_phase    <= phase_r;
      out_position <= pos_cur;
    end
  end

  a_done_silent: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load && phase_r == adsr_pkg::PH_DONE |=> out_scaled == '0)
    else $error("finished envelope produced nonzero output");

  a_restart_pos: assert property (@(posedge clk) disable iff (rst)
    cmd.accept && in_restart |=> pos_cur == '0 && pos_cnt == adsr_pkg::POS_W'(1))
    else $error("restart did not clear the position");

  a_pos_monotonic: assert property (@(posedge clk) disable iff (rst)
    cmd.accept && !in_restart |=> pos_cnt >= $past(pos_cnt) && pos_cur == $past(pos_cnt))
    else $error("position counter moved backward");

endmodule

`default_nettype wire

/* rtl/adsr_envelope_gain_core.sv */
// adsr_envelope_gain_core: four-segment linear envelope applied to a sample
// stream. Top level; depends on adsr_pkg, adsr_if, adsr_ctrl and adsr_dp.
//
// Usage:
//   samples : request channel (valid/ready) carrying sample and restart.
//   results : request channel carrying scaled, phase and position, one
//             result per request, in order.
//   cfg_we/cfg_index/cfg_data : register writes, taken on any edge with
//             cfg_we high; write only while no request is in flight.
// Timing: one request at a time. An accepted request passes through the
//   segment ends, segment select, multiply, divider setup, the bit-per-cycle
//   restoring divider that forms the segment gain slope, gain and product
//   steps into the result register; only then is the next request taken.
// Stall: the result sits in an output register; a new request is accepted
//   while it waits, and processing holds in its last step until the
//   previous result has been taken.
// Reset (synchronous, rst high): all registers read 0, position is 0, no
//   result is pending.
`default_nettype none

module adsr_envelope_gain_core #(
  parameter int MAX_SEGMENT_SAMPLES = 1048575
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  adsr_sample_if.sink                           samples,
  adsr_result_if.source                         results,
  input  wire logic                             cfg_we,
  input  wire logic [adsr_pkg::IDX_W-1:0]        cfg_index,
  input  wire logic [adsr_pkg::CFG_W-1:0]        cfg_data
);

  adsr_pkg::cmd_t    cmd;
  adsr_pkg::status_t status;

  adsr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .cmd       (cmd),
    .status    (status)
  );

  adsr_dp #(
    .MAX_SEGMENT_SAMPLES (MAX_SEGMENT_SAMPLES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_sample    (samples.sample),
    .in_restart   (samples.restart),
    .out_scaled   (results.scaled),
    .out_phase    (results.phase),
    .out_position (results.position)
  );

endmodule

`default_nettype wire

/* dv/adsr_envelope_gain_core_tb.sv */
// Testbench for adsr_envelope_gain_core: drives sample requests and register writes,
// predicts scaled/phase/position per request and checks results in order.
// Depends on adsr_pkg, adsr_if and the core RTL.
`timescale 1ns / 1ps

module adsr_envelope_gain_core_tb;
  import adsr_pkg::*;

  localparam int          MAX_SEGMENT_SAMPLES = 1048575;
  localparam int          CYCLE_LIMIT         = 1500000;
  localparam int          RANDOM_ITEMS        = 1880;
  localparam logic [22:0] POS_MAX             = 23'h7FFFFF;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] scaled;
    logic [PHASE_W-1:0]         phase;
    logic [POS_W-1:0]           position;
  } env_result_t;

  logic clk;
  logic rst;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  adsr_sample_if sample_bus ();
  adsr_result_if result_bus ();

  env_result_t      expected_q [$];
  env_result_t      exp_r;
  logic [CFG_W-1:0] shadow_regs [8];
  logic [POS_W-1:0] position_model;
  int               err_cnt;
  int               cycle_cnt;
  int unsigned      stall_left;
  bit               burst_mode;

  adsr_envelope_gain_core #(
    .MAX_SEGMENT_SAMPLES(MAX_SEGMENT_SAMPLES)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .samples  (sample_bus),
    .results  (result_bus),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("adsr_envelope_gain_core_tb: errors");
      $finish;
    end
  end

  function automatic longint clamp_len(input logic [CFG_W-1:0] v);
    return (v > MAX_SEGMENT_SAMPLES) ? longint'(MAX_SEGMENT_SAMPLES) : longint'(v);
  endfunction

  // from + (to - from) * k / len, truncated toward zero
  function automatic longint seg_gain(input longint from, input longint to,
                                      input longint k, input longint len);
    return from + ((to - from) * k) / len;
  endfunction

  function automatic env_result_t apply_envelope(input logic signed [SAMPLE_W-1:0] smp,
                                                 input logic rs);
    env_result_t r;
    longint la, ld, ls, lr;
    longint e0, e1, e2, e3, pos;
    longint a_lvl, d_lvl, s_lvl, st_lvl;
    longint gain, q;
    la     = clamp_len(shadow_regs[REG_ATTACK_LEN]);
    ld     = clamp_len(shadow_regs[REG_DECAY_LEN]);
    ls     = clamp_len(shadow_regs[REG_SUSTAIN_LEN]);
    lr     = clamp_len(shadow_regs[REG_RELEASE_LEN]);
    a_lvl  = longint'(shadow_regs[REG_ATTACK_LEVEL][LEVEL_W-1:0]);
    d_lvl  = longint'(shadow_regs[REG_DECAY_LEVEL][LEVEL_W-1:0]);
    s_lvl  = longint'(shadow_regs[REG_SUSTAIN_LEVEL][LEVEL_W-1:0]);
    st_lvl = longint'(shadow_regs[REG_START_LEVEL][LEVEL_W-1:0]);
    if (rs) position_model = '0;
    pos = longint'(position_model);
    e0 = la;
    e1 = e0 + ld;
    e2 = e1 + ls;
    e3 = e2 + lr;
    if (pos < e0) begin
      r.phase = PH_ATTACK;
      gain = seg_gain(st_lvl, st_lvl + a_lvl, pos, la);
    end else if (pos < e1) begin
      r.phase = PH_DECAY;
      gain = seg_gain(a_lvl, d_lvl, pos - e0, ld);
    end else if (pos < e2) begin
      r.phase = PH_SUSTAIN;
      gain = seg_gain(d_lvl, s_lvl, pos - e1, ls);
    end else if (pos < e3) begin
      r.phase = PH_RELEASE;
      gain = seg_gain(s_lvl, 0, pos - e2, lr);
    end else begin
      r.phase = PH_DONE;
      gain = 0;
    end
    q = (longint'(smp) * gain) >>> 15;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    r.scaled   = q[SAMPLE_W-1:0];
    r.position = position_model;
    if (position_model < POS_MAX) position_model = position_model + 1'b1;
    return r;
  endfunction

  // result sink: random backpressure, counted from when a result shows up
  always @(posedge clk) begin : result_sink
    int unsigned wait_draw;
    if (rst) begin
      result_bus.ready <= 1'b1;
      stall_left       <= 0;
    end else if (result_bus.valid && result_bus.ready) begin
      wait_draw        = burst_mode ? 0 : $urandom_range(0, 9);
      result_bus.ready <= (wait_draw == 0);
      stall_left       <= (wait_draw == 0) ? 0 : wait_draw - 1;
    end else if (result_bus.valid && !result_bus.ready) begin
      if (stall_left == 0) result_bus.ready <= 1'b1;
      else stall_left <= stall_left - 1;
    end
  end

  task automatic report_mismatch(input string field, input longint expv, input longint act);
    err_cnt++;
    $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, expv, act);
  endtask

  always @(posedge clk) begin
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (expected_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result: expected none, actual scaled %0d phase %0d pos %0d",
                 $time, result_bus.scaled, result_bus.phase, result_bus.position);
      end else begin
        exp_r = expected_q.pop_front();
        if (result_bus.scaled !== exp_r.scaled)
          report_mismatch("scaled", exp_r.scaled, result_bus.scaled);
        if (result_bus.phase !== exp_r.phase)
          report_mismatch("phase", exp_r.phase, result_bus.phase);
        if (result_bus.position !== exp_r.position)
          report_mismatch("position", exp_r.position, result_bus.position);
      end
    end
  end

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp, input logic rs);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      sample_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_bus.valid   <= 1'b1;
    sample_bus.sample  <= smp;
    sample_bus.restart <= rs;
    @(posedge clk);
    while (!sample_bus.ready) @(posedge clk);
    expected_q.push_back(apply_envelope(smp, rs));
  endtask

  task automatic wait_idle();
    sample_bus.valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_envelope(input logic [CFG_W-1:0] a_len, input logic [CFG_W-1:0] d_len,
                                  input logic [CFG_W-1:0] s_len, input logic [CFG_W-1:0] r_len,
                                  input logic [CFG_W-1:0] a_lvl, input logic [CFG_W-1:0] d_lvl,
                                  input logic [CFG_W-1:0] s_lvl, input logic [CFG_W-1:0] st_lvl);
    logic [CFG_W-1:0] vals [8];
    logic [IDX_W-1:0] idx;
    vals[REG_ATTACK_LEN]    = a_len;
    vals[REG_DECAY_LEN]     = d_len;
    vals[REG_SUSTAIN_LEN]   = s_len;
    vals[REG_RELEASE_LEN]   = r_len;
    vals[REG_ATTACK_LEVEL]  = a_lvl;
    vals[REG_DECAY_LEVEL]   = d_lvl;
    vals[REG_SUSTAIN_LEVEL] = s_lvl;
    vals[REG_START_LEVEL]   = st_lvl;
    wait_idle();
    idx = REG_ATTACK_LEN;
    repeat (8) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= vals[idx];
      @(posedge clk);
      shadow_regs[idx] = vals[idx];
      idx = idx + 1'b1;
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [CFG_W-1:0] rand_len();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return CFG_W'($urandom);
      default: return CFG_W'($urandom_range(1, 16));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_level();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CFG_W'(32768);
      2:       return CFG_W'(65535);
      3:       return CFG_W'($urandom);
      default: return CFG_W'($urandom_range(0, 32768));
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return -16'sd32768;
      1:       return 16'sd32767;
      2:       return '0;
      3:       return -16'sd1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // all registers at reset: every segment empty, envelope finished from the start
  task automatic test_reset_defaults();
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd32767, 1'b1);
    send_sample(16'sd0, 1'b0);
  endtask

  task automatic test_full_envelope();
    int k;
    program_envelope(3, 2, 2, 3, 32768, 16384, 8192, 0);
    send_sample(16'sd32767, 1'b1);
    for (k = 1; k <= 10; k++)
      send_sample((k % 2) ? -16'sd32768 : 16'sd32767 - 16'(k), 1'b0);
  endtask

  task automatic test_skipped_segments();
    int k;
    program_envelope(0, 3, 0, 2, 20000, 65535, 1000, 777);
    send_sample(-16'sd1, 1'b1);
    for (k = 1; k <= 5; k++)
      send_sample((k % 2) ? 16'sd32767 : -16'sd30000, 1'b0);
  endtask

  // gains past unity must saturate the product
  task automatic test_unity_overflow();
    program_envelope(2, 1, 1, 1, 65535, 65535, 65535, 65535);
    send_sample(-16'sd32768, 1'b1);
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd32767, 1'b0);
  endtask

  task automatic test_longest_segments();
    program_envelope('1, '1, '1, '1, 32768, 0, 65535, 1);
    send_sample(16'sd32767, 1'b1);
    send_sample(-16'sd32768, 1'b0);
  endtask

  task automatic test_random_envelopes(input int unsigned n_items);
    int unsigned sent;
    int unsigned run_len;
    int unsigned k;
    sent = 0;
    while (sent < n_items) begin
      program_envelope(rand_len(), rand_len(), rand_len(), rand_len(),
                       rand_level(), rand_level(), rand_level(), rand_level());
      burst_mode = ($urandom_range(0, 4) == 0);
      run_len = $urandom_range(8, 60);
      for (k = 0; k < run_len; k++)
        send_sample(rand_sample(),
                    ((k == 0) && ($urandom_range(0, 3) != 0)) || ($urandom_range(0, 39) == 0));
      sent += run_len;
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    sample_bus.valid   = 1'b0;
    sample_bus.sample  = '0;
    sample_bus.restart = 1'b0;
    result_bus.ready   = 1'b0;
    err_cnt            = 0;
    cycle_cnt          = 0;
    stall_left         = 0;
    burst_mode         = 1'b0;
    position_model     = '0;
    foreach (shadow_regs[i]) shadow_regs[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_full_envelope();
    test_skipped_segments();
    test_unity_overflow();
    test_longest_segments();
    test_random_envelopes(RANDOM_ITEMS);
    wait_idle();
    repeat (30) @(posedge clk);
    if (err_cnt == 0)
      $display("adsr_envelope_gain_core_tb: clean");
    else
      $display("adsr_envelope_gain_core_tb: errors");
    $finish;
  end

endmodule

/* filelist.f */
rtl/adsr_pkg.sv
rtl/adsr_if.sv
rtl/adsr_ctrl.sv
rtl/adsr_dp.sv
rtl/adsr_envelope_gain_core.sv
dv/adsr_envelope_gain_core_tb.sv
